// ===== src/rbr_pkg.sv =====
// ----------------------------------------------------------------------------
// rbr_pkg: shared types and constants of the rotated blit
// Payload structs of the pixel and result channels, the register set, the
// register indexes and the rotation codes.
// ----------------------------------------------------------------------------
package rbr_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_LEFT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_TOP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_COLUMN   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_ROW      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PITCH  = 3'd7;

  // Rotation codes; the unused code walks like ROT_NONE
  localparam logic [1:0] ROT_NONE  = 2'd0;
  localparam logic [1:0] ROT_90    = 2'd1;
  localparam logic [1:0] ROT_270   = 2'd2;
  localparam logic [1:0] ROT_SPARE = 2'd3;

  localparam logic [10:0] SOURCE_PITCH_RESET = 11'd720;

  typedef struct packed {
    logic [7:0] pixel_byte0;
    logic [7:0] pixel_byte1;
    logic [7:0] pixel_byte2;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  packed_byte0;
    logic [7:0]  packed_byte1;
    logic [1:0]  packed_byte2;
    logic [18:0] source_offset;
    logic [17:0] dest_offset;
    logic        out_of_range;
    logic        last_pixel;
  } result_t;

  typedef struct packed {
    logic [1:0]  rotation_mode;
    logic [8:0]  source_left;
    logic [8:0]  source_top;
    logic [8:0]  rect_width;
    logic [8:0]  rect_height;
    logic [7:0]  dest_column;
    logic [8:0]  dest_row;
    logic [10:0] source_pitch;
  } cfg_regs_t;

  // Address side of one result, from the walker
  typedef struct packed {
    logic [18:0] source_offset;
    logic [17:0] dest_offset;
    logic        out_of_range;
    logic        last_pixel;
  } walk_t;

  // Pack a 24-bit pixel into the 18-bit frame buffer layout, attach offsets
  function automatic result_t pack_pixel(pixel_t p, walk_t w);
    result_t r;
    r.packed_byte0  = {p.pixel_byte1[3:2], p.pixel_byte0[7:2]};
    r.packed_byte1  = {p.pixel_byte2[5:2], p.pixel_byte1[7:4]};
    r.packed_byte2  = p.pixel_byte2[7:6];
    r.source_offset = w.source_offset;
    r.dest_offset   = w.dest_offset;
    r.out_of_range  = w.out_of_range;
    r.last_pixel    = w.last_pixel;
    return r;
  endfunction

endpackage

// ===== src/rotated_blit_rgb888_to_rgb666.sv =====
// ----------------------------------------------------------------------------
// rotated_blit_rgb888_to_rgb666: rotated rectangle blit, 24 to 18-bit pixels
// Packs each source pixel for the frame buffer and walks source and
// destination byte offsets, unrotated or rotated by 90 or 270 degrees.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : three-byte source pixels of the rectangle in row order. A
//            transfer happens when pixel_valid is high and pixel_stall low.
//   result : packed pixel, source and destination offsets, range flag and
//            last-pixel mark; one result per pixel, in order.
//   cfg    : register writes (index, data), cfg_ready is always high. Write
//            only while no pixel is in flight. Any write restarts the walk.
// The result is registered: result_valid rises in the cycle after the pixel
// transfer. Throughput is one pixel per cycle while the result side does not
// stall; the pixel side also stalls after reset or a register write, when the
// start offsets are reloaded through the row-times-pitch multiplier and
// pixel_stall is held high.
// A stalled result sits in the output register while one more pixel is
// taken into a spare entry; pixel_stall then rises until the result drains.
// Reset (synchronous, active high) restores default registers, empties the
// result buffer and restarts the walk at the rectangle's first pixel.
// ----------------------------------------------------------------------------
module rotated_blit_rgb888_to_rgb666
  import rbr_pkg::*;
#(
  parameter int LINE_PITCH  = 720,
  parameter int SCREEN_ROWS = 320
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_regs_t regs;
  walk_t     walk;
  logic      reload;
  logic      skid_full;
  logic      accept;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  rbr_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .write  (cfg_valid),
    .index  (cfg_index),
    .data   (cfg_data),
    .regs   (regs),
    .reload (reload)
  );

  // Hold the pixel side during a reload or while the spare entry is taken
  assign pixel_stall = reload | skid_full;
  assign accept      = pixel_valid & ~pixel_stall;

  rbr_walker #(
    .LINE_PITCH  (LINE_PITCH),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .reload  (reload),
    .advance (accept),
    .walk    (walk)
  );

  rbr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (pack_pixel(pixel, walk)),
    .full      (skid_full),
    .valid     (result_valid),
    .item      (result),
    .stall     (result_stall)
  );

  // A register write must stall the next pixel while start offsets reload
  a_cfg_reload: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> pixel_stall)
    else $error("pixel not stalled after register write");

  // Every transfer leaves a result waiting in the output register
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted pixel produced no result");

  // A transfer behind a stalled result fills the spare entry
  a_spare_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && result_valid && result_stall) |=> (skid_full && pixel_stall))
    else $error("spare entry not filled behind stalled result");

endmodule

// ===== src/rbr_cfg.sv =====
// ----------------------------------------------------------------------------
// rbr_cfg: configuration register file
// Holds the blit registers and flags a reload of the walk start after reset
// and after every register write.
// ----------------------------------------------------------------------------
module rbr_cfg
  import rbr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write,
  input  logic [CFG_INDEX_W-1:0] index,
  input  logic [CFG_DATA_W-1:0]  data,
  output cfg_regs_t              regs,
  output logic                   reload
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rotation_mode <= ROT_NONE;
      regs.source_left   <= '0;
      regs.source_top    <= '0;
      regs.rect_width    <= 9'd1;
      regs.rect_height   <= 9'd1;
      regs.dest_column   <= '0;
      regs.dest_row      <= '0;
      regs.source_pitch  <= SOURCE_PITCH_RESET;
      reload             <= 1'b1;
    end else begin
      reload <= write;
      if (write) begin
        unique case (index)
          REG_ROTATION_MODE: regs.rotation_mode <= data[1:0];
          REG_SOURCE_LEFT:   regs.source_left   <= data[8:0];
          REG_SOURCE_TOP:    regs.source_top    <= data[8:0];
          REG_RECT_WIDTH:    regs.rect_width    <= data[8:0];
          REG_RECT_HEIGHT:   regs.rect_height   <= data[8:0];
          REG_DEST_COLUMN:   regs.dest_column   <= data[7:0];
          REG_DEST_ROW:      regs.dest_row      <= data[8:0];
          REG_SOURCE_PITCH:  regs.source_pitch  <= data;
        endcase
      end
    end
  end

endmodule

// ===== src/rbr_walker.sv =====
// ----------------------------------------------------------------------------
// rbr_walker: source and destination offset walker
// Keeps the row and column counters and the running offsets, gives the
// offsets of the current pixel and advances once per accepted pixel.
// ----------------------------------------------------------------------------
module rbr_walker
  import rbr_pkg::*;
#(
  parameter int LINE_PITCH  = 720,
  parameter int SCREEN_ROWS = 320
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t regs,
  input  logic      reload,
  input  logic      advance,
  output walk_t     walk
);

  // Bound on any destination offset magnitude reachable by the walk
  localparam int DST_SPAN = 1022 * LINE_PITCH + 2300 + LINE_PITCH * SCREEN_ROWS;
  localparam int DW       = $clog2(DST_SPAN) + 1;
  localparam int DXW      = (DW > 18) ? DW : 18;

  localparam logic signed [DW-1:0] PITCH_S = DW'(LINE_PITCH);
  localparam logic signed [DW-1:0] THREE_S = DW'(3);
  localparam logic signed [DW-1:0] FB_LAST = DW'(LINE_PITCH * SCREEN_ROWS - 3);

  logic [8:0]           column_count;
  logic [8:0]           row_count;
  logic [18:0]          source_row_base;
  logic signed [DW-1:0] dest_row_base;
  logic signed [DW-1:0] dest_cursor;

  logic [8:0]           width_eff;
  logic [8:0]           height_eff;
  logic                 col_done;
  logic                 row_done;
  logic [20:0]          src_start_wide;
  logic [18:0]          src_start;
  logic signed [DW-1:0] dst_start;
  logic signed [DW-1:0] col_step;
  logic signed [DW-1:0] row_step;
  logic [DXW-1:0]       dst_ext;
  logic                 oor;

  always_comb begin
    width_eff  = (regs.rect_width == '0) ? 9'd1 : regs.rect_width;
    height_eff = (regs.rect_height == '0) ? 9'd1 : regs.rect_height;
    col_done   = ({1'b0, column_count} + 10'd1) >= {1'b0, width_eff};
    row_done   = ({1'b0, row_count} + 10'd1) >= {1'b0, height_eff};

    src_start_wide = 21'(regs.source_top) * 21'(regs.source_pitch)
                   + 21'(regs.source_left) * 21'd3;
    src_start      = src_start_wide[18:0];
    dst_start      = $signed(DW'(DW'(regs.dest_row) * DW'(LINE_PITCH)
                                 + DW'(regs.dest_column) * DW'(3)));

    unique case (regs.rotation_mode)
      ROT_90: begin
        col_step = -PITCH_S;
        row_step = THREE_S;
      end
      ROT_270: begin
        col_step = PITCH_S;
        row_step = -THREE_S;
      end
      default: begin
        col_step = THREE_S;
        row_step = PITCH_S;
      end
    endcase
  end

  always_comb begin
    oor     = (dest_cursor < 0) || (dest_cursor > FB_LAST);
    dst_ext = DXW'($unsigned(dest_cursor));
    walk.source_offset = source_row_base + 19'(column_count) * 19'd3;
    walk.dest_offset   = oor ? '0 : dst_ext[17:0];
    walk.out_of_range  = oor;
    walk.last_pixel    = col_done && row_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (reload || (advance && col_done && row_done)) begin
      // restart at the first pixel of the rectangle
      column_count    <= '0;
      row_count       <= '0;
      source_row_base <= src_start;
      dest_row_base   <= dst_start;
      dest_cursor     <= dst_start;
    end else if (advance) begin
      if (!col_done) begin
        column_count <= column_count + 9'd1;
        dest_cursor  <= dest_cursor + col_step;
      end else begin
        column_count    <= '0;
        row_count       <= row_count + 9'd1;
        source_row_base <= source_row_base + 19'(regs.source_pitch);
        dest_row_base   <= dest_row_base + row_step;
        dest_cursor     <= dest_row_base + row_step;
      end
    end
  end

endmodule

// ===== src/rbr_skid.sv =====
// ----------------------------------------------------------------------------
// rbr_skid: two-entry result buffer
// Output register plus a spare entry, so a pixel can be taken while a result
// is stalled; full is registered and stalls the pixel side.
// ----------------------------------------------------------------------------
module rbr_skid
  import rbr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_item,
  output logic    full,
  output logic    valid,
  output result_t item,
  input  logic    stall
);

  result_t spare;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      full  <= 1'b0;
    end else if (push) begin
      if (!valid || !stall) begin
        valid <= 1'b1;
        item  <= push_item;
      end else begin
        full  <= 1'b1;
        spare <= push_item;
      end
    end else if (valid && !stall) begin
      if (full) begin
        item <= spare;
        full <= 1'b0;
      end else begin
        valid <= 1'b0;
      end
    end
  end

endmodule

// ===== bench/tb_rotated_blit_rgb888_to_rgb666.sv =====
// ----------------------------------------------------------------------------
// tb_rotated_blit_rgb888_to_rgb666: self-checking bench of the rotated blit
// Streams source pixels through the block under several register settings,
// predicts every packed pixel and its source and destination offsets in a
// local walker, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module tb_rotated_blit_rgb888_to_rgb666;
  import rbr_pkg::*;

  // Frame buffer geometry, handed to the block as well
  localparam int FB_PITCH    = 720;
  localparam int FB_ROWS     = 320;
  localparam int FB_BYTES    = FB_PITCH * FB_ROWS;
  localparam int PIXEL_BYTES = 3;

  // Run shape
  localparam int RANDOM_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  pixel_t                 pixel = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  rotated_blit_rgb888_to_rgb666 #(
    .LINE_PITCH  (FB_PITCH),
    .SCREEN_ROWS (FB_ROWS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the register set and of the rectangle walk
  // --------------------------------------------------------------------------
  cfg_regs_t   blit_regs;
  logic [8:0]  walk_col;
  logic [8:0]  walk_row;
  logic [18:0] src_line_base;
  int          dst_line_base;   // signed: rotation may walk below zero
  int          dst_addr;

  result_t     pending_results[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          gaps_enabled = 1'b1;
  int          hold_requests = 0;

  // Return to the rectangle's first pixel and recompute the start offsets
  function automatic void restart_walk();
    walk_col      = '0;
    walk_row      = '0;
    src_line_base = 19'(int'(blit_regs.source_top) * int'(blit_regs.source_pitch)
                        + int'(blit_regs.source_left) * PIXEL_BYTES);
    dst_line_base = int'(blit_regs.dest_row) * FB_PITCH
                    + int'(blit_regs.dest_column) * PIXEL_BYTES;
    dst_addr      = dst_line_base;
  endfunction

  function automatic void load_defaults();
    blit_regs               = '0;
    blit_regs.rotation_mode = ROT_NONE;
    blit_regs.rect_width    = 9'd1;
    blit_regs.rect_height   = 9'd1;
    blit_regs.source_pitch  = SOURCE_PITCH_RESET;
    restart_walk();
  endfunction

  // Pack one source pixel, attach its offsets and advance the walk
  function automatic result_t walk_and_pack(pixel_t p);
    result_t     r;
    int          w;
    int          h;
    int          col_step;
    int          row_step;
    logic        oor;
    logic        last;
    w    = (blit_regs.rect_width == 0) ? 1 : int'(blit_regs.rect_width);
    h    = (blit_regs.rect_height == 0) ? 1 : int'(blit_regs.rect_height);
    oor  = (dst_addr < 0) || (dst_addr > FB_BYTES - PIXEL_BYTES);
    last = (int'(walk_col) + 1 >= w) && (int'(walk_row) + 1 >= h);
    case (blit_regs.rotation_mode)
      ROT_90: begin
        col_step = -FB_PITCH;
        row_step = PIXEL_BYTES;
      end
      ROT_270: begin
        col_step = FB_PITCH;
        row_step = -PIXEL_BYTES;
      end
      default: begin
        // the unused code walks unrotated too
        col_step = PIXEL_BYTES;
        row_step = FB_PITCH;
      end
    endcase

    r.packed_byte0  = (p.pixel_byte0 >> 2) | ((p.pixel_byte1 & 8'h0c) << 4);
    r.packed_byte1  = (p.pixel_byte1 >> 4) | ((p.pixel_byte2 & 8'h3c) << 2);
    r.packed_byte2  = p.pixel_byte2[7:6];
    r.source_offset = 19'(int'(src_line_base) + int'(walk_col) * PIXEL_BYTES);
    r.dest_offset   = oor ? '0 : 18'(dst_addr);
    r.out_of_range  = oor;
    r.last_pixel    = last;

    if (int'(walk_col) + 1 < w) begin
      walk_col = walk_col + 9'd1;
      dst_addr = dst_addr + col_step;
    end else if (int'(walk_row) + 1 < h) begin
      walk_col      = '0;
      walk_row      = walk_row + 9'd1;
      src_line_base = src_line_base + 19'(blit_regs.source_pitch);
      dst_line_base = dst_line_base + row_step;
      dst_addr      = dst_line_base;
    end else begin
      restart_walk();
    end
    return r;
  endfunction

  initial load_defaults();

  // --------------------------------------------------------------------------
  // Result checker: compare every result transfer with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("packed_byte0", 32'(want.packed_byte0), 32'(result.packed_byte0));
        check_field("packed_byte1", 32'(want.packed_byte1), 32'(result.packed_byte1));
        check_field("packed_byte2", 32'(want.packed_byte2), 32'(result.packed_byte2));
        check_field("source_offset", 32'(want.source_offset), 32'(result.source_offset));
        check_field("dest_offset", 32'(want.dest_offset), 32'(result.dest_offset));
        check_field("out_of_range", 32'(want.out_of_range), 32'(result.out_of_range));
        check_field("last_pixel", 32'(want.last_pixel), 32'(result.last_pixel));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in phases of random density, including calm phases, and
  // hold off for a long stretch whenever a test asks for it
  // --------------------------------------------------------------------------
  int holds_served = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int stall_phase_left = 0;

  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (stall_phase_left == 0) begin
        stall_phase_left = $urandom_range(200, 10);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_phase_left--;
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transfer of any kind happens for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one pixel, hold it until the transfer, then record its prediction.
  // Work in bursts; between bursts valid may drop for a random gap.
  task automatic send_pixel(input pixel_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      gap = (!gaps_enabled || $urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    pending_results.push_back(walk_and_pack(p));
    burst_left--;
  endtask

  // Drop valid and wait until every predicted result has been checked
  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write one register once the block is idle; mirror it in the local copy
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROTATION_MODE: blit_regs.rotation_mode = value[1:0];
      REG_SOURCE_LEFT:   blit_regs.source_left   = value[8:0];
      REG_SOURCE_TOP:    blit_regs.source_top    = value[8:0];
      REG_RECT_WIDTH:    blit_regs.rect_width    = value[8:0];
      REG_RECT_HEIGHT:   blit_regs.rect_height   = value[8:0];
      REG_DEST_COLUMN:   blit_regs.dest_column   = value[7:0];
      REG_DEST_ROW:      blit_regs.dest_row      = value[8:0];
      default:           blit_regs.source_pitch  = value;
    endcase
    restart_walk();
    @(posedge clk);
  endtask

  task automatic set_rect(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_RECT_WIDTH, w);
    write_reg(REG_RECT_HEIGHT, h);
  endtask

  task automatic set_dest(input logic [CFG_DATA_W-1:0] col, input logic [CFG_DATA_W-1:0] row);
    write_reg(REG_DEST_COLUMN, col);
    write_reg(REG_DEST_ROW, row);
  endtask

  function automatic pixel_t random_pixel();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return pixel_t'($urandom());
    endcase
  endfunction

  // Register value: mostly inside the legal range, often at its ends, and
  // now and then anything the field can carry
  function automatic logic [CFG_DATA_W-1:0] pick_value(int lo, int hi, int width);
    int r;
    r = $urandom_range(99);
    if (r < 12) return CFG_DATA_W'(lo);
    if (r < 24) return CFG_DATA_W'(hi);
    if (r < 32) return CFG_DATA_W'($urandom_range((1 << width) - 1));
    return CFG_DATA_W'($urandom_range(hi, lo));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: a 1x1 rectangle at offset 0, every pixel the last one
  task automatic test_default_walk();
    send_pixel('0);
    send_pixel('1);
  endtask

  // Bit packing of the three bytes and the step to the next source row
  task automatic test_pixel_packing();
    set_rect(2, 2);
    send_pixel(24'h555555);
    send_pixel(24'hAAAAAA);
    send_pixel(24'h0C3CC0);
    send_pixel(24'hF3C303);
  endtask

  // Rotations 90 and 270 and the unused code on a 2x2 rectangle in the middle of the frame buffer
  task automatic test_rotations();
    set_dest(100, 100);
    write_reg(REG_ROTATION_MODE, CFG_DATA_W'(ROT_90));
    repeat (4) send_pixel(random_pixel());
    write_reg(REG_ROTATION_MODE, CFG_DATA_W'(ROT_270));
    repeat (4) send_pixel(random_pixel());
    // unused code: walk as unrotated
    write_reg(REG_ROTATION_MODE, CFG_DATA_W'(ROT_SPARE));
    repeat (4) send_pixel(random_pixel());
  endtask

  // Zero size, destination leaving the frame buffer, source offset wrap
  task automatic test_special_cases();
    write_reg(REG_ROTATION_MODE, CFG_DATA_W'(ROT_NONE));
    set_rect(0, 0);
    send_pixel(random_pixel());

    // rotate 90 from the top line: the second pixel lands above the buffer
    write_reg(REG_ROTATION_MODE, CFG_DATA_W'(ROT_90));
    set_dest(239, 0);
    set_rect(2, 1);
    send_pixel(random_pixel());
    send_pixel(random_pixel());

    // unrotated from the last pixel of the buffer: step past its end
    write_reg(REG_ROTATION_MODE, CFG_DATA_W'(ROT_NONE));
    set_dest(239, 319);
    send_pixel(random_pixel());
    send_pixel(random_pixel());

    // row beyond the buffer straight away
    set_dest(0, 511);
    set_rect(1, 1);
    send_pixel(random_pixel());

    // source start beyond the 19-bit range, then a row step that wraps again
    write_reg(REG_SOURCE_LEFT, 511);
    write_reg(REG_SOURCE_TOP, 511);
    write_reg(REG_SOURCE_PITCH, 2047);
    set_rect(1, 2);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
  endtask

  // Hold the receiver off for a long stretch while pixels keep coming, so
  // the block fills up and stalls its input
  task automatic test_backpressure();
    write_reg(REG_SOURCE_LEFT, 0);
    write_reg(REG_SOURCE_TOP, 0);
    write_reg(REG_SOURCE_PITCH, 720);
    set_dest(0, 0);
    set_rect(16, 4);
    hold_requests <= hold_requests + 1;
    gaps_enabled = 1'b0;
    repeat (64) send_pixel(random_pixel());
    gaps_enabled = 1'b1;
    drain_results();
  endtask

  // Random settings, mostly whole rectangles, some cut short or overrun
  task automatic test_random_rectangles();
    int sent;
    int w;
    int h;
    int area;
    int count;
    int r;
    bit write_all;
    sent = 0;
    write_all = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      // rectangle size: small mostly, zero now and then, rarely the largest
      r = $urandom_range(99);
      if (r < 4) begin
        w = $urandom_range(1) ? 0 : $urandom_range(6, 1);
        h = (w == 0) ? $urandom_range(6, 0) : 0;
      end else if (r < 6) begin
        w = ($urandom_range(2) == 0) ? 511 : 320;
        h = 1;
        if ($urandom_range(1)) begin
          h = w;
          w = 1;
        end
      end else begin
        w = $urandom_range(8, 1);
        h = $urandom_range(6, 1);
      end

      if (write_all || $urandom_range(1)) begin
        write_reg(REG_ROTATION_MODE, pick_value(0, 2, 2));
        write_reg(REG_SOURCE_LEFT, pick_value(0, 319, 9));
        write_reg(REG_SOURCE_TOP, pick_value(0, 319, 9));
        write_reg(REG_DEST_COLUMN, pick_value(0, 239, 8));
        write_reg(REG_DEST_ROW, pick_value(0, 319, 9));
        write_reg(REG_SOURCE_PITCH, pick_value(3, 1024, 11));
        set_rect(CFG_DATA_W'(w), CFG_DATA_W'(h));
      end else begin
        if ($urandom_range(1)) write_reg(REG_ROTATION_MODE, pick_value(0, 2, 2));
        if ($urandom_range(1)) write_reg(REG_DEST_COLUMN, pick_value(0, 239, 8));
        if ($urandom_range(1)) write_reg(REG_DEST_ROW, pick_value(0, 319, 9));
        if ($urandom_range(1)) write_reg(REG_SOURCE_LEFT, pick_value(0, 319, 9));
        if ($urandom_range(1)) set_rect(CFG_DATA_W'(w), CFG_DATA_W'(h));
      end
      write_all = 1'b0;

      // advance through the rectangle as currently set in the local copy
      area = ((blit_regs.rect_width == 0) ? 1 : int'(blit_regs.rect_width))
             * ((blit_regs.rect_height == 0) ? 1 : int'(blit_regs.rect_height));
      r = $urandom_range(99);
      if (r < 70)      count = area;
      else if (r < 85) count = $urandom_range(area, 1);
      else             count = area + $urandom_range(5, 1);
      repeat (count) send_pixel(random_pixel());
      sent += count;
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_default_walk();
    test_pixel_packing();
    test_rotations();
    test_special_cases();
    test_backpressure();
    test_random_rectangles();

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
